>>> hdl/utf8_to_utf32_stream_decoder_defines.svh
// Assertion macros shared by the UTF-8 decoder RTL files
`ifndef UTF8_TO_UTF32_STREAM_DECODER_DEFINES_SVH
`define UTF8_TO_UTF32_STREAM_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset
`define U8DEC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included
`define U8DEC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define U8DEC_ASSERT(lbl, prop, msg)
`define U8DEC_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

>>> hdl/u8dec_pkg.sv
// Types and constants of the UTF-8 to UTF-32 stream decoder
`timescale 1ns / 1ps

package u8dec_pkg;

  localparam int unsigned CpWidth = 31;
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);

  // Payload masks of the lead byte classes and of a continuation byte
  localparam logic [7:0] ContMask  = 8'h3F;
  localparam logic [7:0] Lead2Mask = 8'h1F;
  localparam logic [7:0] Lead3Mask = 8'h0F;
  localparam logic [7:0] Lead4Mask = 8'h07;
  localparam logic [7:0] Lead5Mask = 8'h03;
  localparam logic [7:0] Lead6Mask = 8'h01;

  // Continuation bytes still expected after each lead class
  localparam logic [2:0] Need2 = 3'd1;
  localparam logic [2:0] Need3 = 3'd2;
  localparam logic [2:0] Need4 = 3'd3;
  localparam logic [2:0] Need5 = 3'd4;
  localparam logic [2:0] Need6 = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } u8dec_in_t;

  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic               is_terminator;
  } u8dec_out_t;

  // Results of one byte handed to the result queue
  typedef struct packed {
    logic [1:0] cnt;
    u8dec_out_t r0;
    u8dec_out_t r1;
  } u8dec_push_t;

endpackage

>>> hdl/u8dec_in_reg.sv
// Input register stage: holds one accepted byte beat until the decoder takes it
`timescale 1ns / 1ps

module u8dec_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  u8dec_pkg::u8dec_in_t in_data,
  input  logic                take,
  output logic                hold_valid,
  output u8dec_pkg::u8dec_in_t hold_data
);
  import u8dec_pkg::*;

  logic      hv_r, hv_nxt;
  u8dec_in_t hd_r;

  // Accept a new beat when the register is empty or being drained this cycle
  assign in_ready = !hv_r || take;

  always_comb begin
    hv_nxt = hv_r;
    if (in_valid && in_ready) begin
      hv_nxt = 1'b1;
    end else if (take) begin
      hv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r <= 1'b0;
    end else begin
      hv_r <= hv_nxt;
    end
  end

  // Capture payload on accept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hd_r <= in_data;
    end
  end

  assign hold_valid = hv_r;
  assign hold_data  = hd_r;

endmodule

>>> hdl/u8dec_core.sv
// Decoder core: sequence state and per-byte decode into up to two results
`timescale 1ns / 1ps
`include "utf8_to_utf32_stream_decoder_defines.svh"

module u8dec_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  u8dec_pkg::u8dec_in_t  beat,
  output u8dec_pkg::u8dec_push_t push
);
  import u8dec_pkg::*;

  logic [CpWidth-1:0] partial_r, partial_nxt;
  logic [2:0]         need_r, need_nxt;
  logic               nul_r, nul_nxt;
  logic               emit;
  logic [CpWidth-1:0] cp;
  logic [7:0]         b;

  assign b = beat.data_byte;

  // Decode one byte against the current sequence state
  always_comb begin
    partial_nxt = partial_r;
    need_nxt    = need_r;
    nul_nxt     = nul_r;
    emit        = 1'b0;
    cp          = '0;
    if (nul_r) begin
      // drop everything after a zero lead byte
    end else if (need_r != 3'd0) begin
      cp          = {partial_r[CpWidth-7:0], b[5:0] & ContMask[5:0]};
      need_nxt    = need_r - 3'd1;
      partial_nxt = cp;
      if (need_r == 3'd1) begin
        emit        = 1'b1;
        partial_nxt = '0;
      end
    end else begin
      case (b) inside
        8'h00: begin
          nul_nxt = 1'b1;
        end
        [8'h01:8'h7F]: begin
          emit = 1'b1;
          cp   = {{(CpWidth-8){1'b0}}, b};
        end
        [8'h80:8'hBF]: begin
          // skip stray continuation byte
        end
        [8'hC0:8'hDF]: begin
          partial_nxt = {{(CpWidth-8){1'b0}}, b & Lead2Mask};
          need_nxt    = Need2;
        end
        [8'hE0:8'hEF]: begin
          partial_nxt = {{(CpWidth-8){1'b0}}, b & Lead3Mask};
          need_nxt    = Need3;
        end
        [8'hF0:8'hF7]: begin
          partial_nxt = {{(CpWidth-8){1'b0}}, b & Lead4Mask};
          need_nxt    = Need4;
        end
        [8'hF8:8'hFB]: begin
          partial_nxt = {{(CpWidth-8){1'b0}}, b & Lead5Mask};
          need_nxt    = Need5;
        end
        default: begin
          partial_nxt = {{(CpWidth-8){1'b0}}, b & Lead6Mask};
          need_nxt    = Need6;
        end
      endcase
    end
    // Clear all state at the end of a buffer
    if (beat.buffer_end) begin
      partial_nxt = '0;
      need_nxt    = 3'd0;
      nul_nxt     = 1'b0;
    end
  end

  // Pack results: code point first, terminator after it
  always_comb begin
    push.cnt              = {1'b0, emit} + {1'b0, beat.buffer_end};
    push.r0.code_point    = emit ? cp : '0;
    push.r0.is_terminator = !emit;
    push.r1.code_point    = '0;
    push.r1.is_terminator = 1'b1;
  end

  // Advance state only when a beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      need_r    <= 3'd0;
      nul_r     <= 1'b0;
    end else if (fire) begin
      partial_r <= partial_nxt;
      need_r    <= need_nxt;
      nul_r     <= nul_nxt;
    end
  end

  `U8DEC_ASSERT(a_need_range, need_r <= Need6, "continuation count out of range")
  `U8DEC_ASSERT(a_nul_idle, !nul_r || need_r == 3'd0, "open sequence after zero lead")
  `U8DEC_ASSERT(a_end_clears, fire && beat.buffer_end |=> need_r == 3'd0 && !nul_r && partial_r == '0, "state not cleared at buffer end")

endmodule

>>> hdl/u8dec_fifo.sv
// Result queue: takes up to two results per cycle, hands out one beat per cycle while out_ready is high
`timescale 1ns / 1ps
`include "utf8_to_utf32_stream_decoder_defines.svh"

module u8dec_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push_en,
  input  u8dec_pkg::u8dec_push_t push,
  output logic                   room,
  output logic                   out_valid,
  input  logic                   out_ready,
  output u8dec_pkg::u8dec_out_t  out_data
);
  import u8dec_pkg::*;

  u8dec_out_t       mem [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0] count_r, count_nxt;
  logic [1:0]       n_push;
  logic             pop;

  assign n_push    = push_en ? push.cnt : 2'd0;
  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != '0);
  assign out_data  = mem[rd_ptr_r];
  // Leave space for the two results a single byte can give
  assign room      = (count_r <= QCntW'(QDepth - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPtrW'(n_push);
    rd_ptr_nxt = rd_ptr_r + QPtrW'(pop);
    count_nxt  = count_r + QCntW'(n_push) - QCntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Write the first result and, for a pair, the second one behind it
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem[wr_ptr_r] <= push.r0;
    end
    if (n_push == 2'd2) begin
      mem[QPtrW'(wr_ptr_r + 1'b1)] <= push.r1;
    end
  end

  `U8DEC_ASSERT(a_no_overflow, n_push != 2'd0 |-> room, "push into full result queue")
  `U8DEC_ASSERT(a_count_track, 1'b1 |=> count_r == $past(count_r) + QCntW'($past(n_push)) - QCntW'($past(pop)), "result count mismatch")
  `U8DEC_ASSERT(a_count_max, count_r <= QCntW'(QDepth), "result count above depth")

endmodule

>>> hdl/utf8_to_utf32_stream_decoder.sv
// Top level of the UTF-8 to UTF-32 stream decoder
//
//   channel  ports                      beat
//   input    in_valid/in_ready/in_data  one UTF-8 byte, flag on last byte
//   output   out_valid/out_ready/out_data  one code point or buffer terminator
//
// A byte is registered in the input register and then written into the result
// queue; its result is offered at the output only once it sits in the queue.
// One byte per cycle is sustained while the queue has room; a byte giving two
// results (a code point completed on the last byte) hands them out one after
// the other through the queue's single read port.
// Reset (rst_n low, synchronous) empties both stages and clears the decode state.
// Output stalls back up through the 4-entry queue into in_ready.
`timescale 1ns / 1ps

module utf8_to_utf32_stream_decoder (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  u8dec_pkg::u8dec_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output u8dec_pkg::u8dec_out_t out_data
);
  import u8dec_pkg::*;

  logic        hold_valid;
  u8dec_in_t   hold_data;
  logic        room;
  logic        fire;
  u8dec_push_t push;

  // Decode the held byte when the queue can take its results
  assign fire = hold_valid && room;

  u8dec_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .take       (fire),
    .hold_valid (hold_valid),
    .hold_data  (hold_data)
  );

  u8dec_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .beat  (hold_data),
    .push  (push)
  );

  u8dec_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (fire),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> tb/tb.sv
// Self-checking testbench for the UTF-8 to UTF-32 stream decoder
`timescale 1ns / 1ps

module tb;
  import u8dec_pkg::*;

  // Continuation and multi-byte lead prefixes, and the byte that ends a string
  localparam logic [7:0] NulByte  = 8'h00;
  localparam logic [7:0] ContTag  = 8'h80;
  localparam logic [7:0] Lead2Tag = 8'hC0;
  localparam logic [7:0] Lead3Tag = 8'hE0;
  localparam logic [7:0] Lead4Tag = 8'hF0;
  localparam logic [7:0] Lead5Tag = 8'hF8;
  localparam logic [7:0] Lead6Tag = 8'hFC;

  localparam int unsigned IdleLimit   = 1000;
  localparam int unsigned DrainCycles = 10;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  u8dec_in_t  in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  u8dec_out_t out_data;

  // Decoder state mirrored by the predictor
  logic [CpWidth-1:0] acc_value = '0;
  logic [2:0]         cont_left = '0;
  logic               nul_seen = 1'b0;

  u8dec_out_t  decoded_q[$];
  logic [7:0]  octet_q[$];

  bit          gaps_on = 1'b1;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned bytes_sent = 0;
  int unsigned live_bytes = 0;
  int unsigned buffers_sent = 0;
  int unsigned cps_checked = 0;
  int unsigned terms_checked = 0;
  int unsigned err_cnt = 0;

  utf8_to_utf32_stream_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Queue one expected result
  task automatic expect_result(input logic [CpWidth-1:0] cp, input logic term);
    u8dec_out_t res;
    res.code_point    = cp;
    res.is_terminator = term;
    decoded_q.push_back(res);
  endtask

  // Advance the decode state by one accepted byte
  task automatic decode_byte(input u8dec_in_t beat);
    logic [7:0] b;
    b = beat.data_byte;
    if (!nul_seen) live_bytes++;
    if (nul_seen) begin
      // drop everything up to the end of the buffer
    end else if (cont_left != 3'd0) begin
      acc_value = {acc_value[CpWidth-7:0], b[5:0]};
      cont_left = cont_left - 3'd1;
      if (cont_left == 3'd0) begin
        expect_result(acc_value, 1'b0);
        acc_value = '0;
      end
    end else if (b == NulByte) begin
      nul_seen = 1'b1;
    end else if (!b[7]) begin
      expect_result(CpWidth'(b), 1'b0);
    end else if (!b[6]) begin
      // stray continuation byte in lead position: skip
    end else if (!b[5]) begin
      acc_value = CpWidth'(b & Lead2Mask);
      cont_left = Need2;
    end else if (!b[4]) begin
      acc_value = CpWidth'(b & Lead3Mask);
      cont_left = Need3;
    end else if (!b[3]) begin
      acc_value = CpWidth'(b & Lead4Mask);
      cont_left = Need4;
    end else if (!b[2]) begin
      acc_value = CpWidth'(b & Lead5Mask);
      cont_left = Need5;
    end else begin
      acc_value = CpWidth'(b & Lead6Mask);
      cont_left = Need6;
    end
    // close the buffer and clear the state
    if (beat.buffer_end) begin
      expect_result('0, 1'b1);
      acc_value = '0;
      cont_left = '0;
      nul_seen  = 1'b0;
    end
  endtask

  // Send one byte and hold it until accepted
  task automatic send_byte(input logic [7:0] octet, input logic last);
    int unsigned gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_data.data_byte    <= octet;
    in_data.buffer_end   <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_byte(in_data);
    bytes_sent++;
  endtask

  // Send the gathered bytes as one buffer, flag on the final byte
  task automatic flush_buffer();
    int unsigned i;
    for (i = 0; i < octet_q.size(); i++) begin
      send_byte(octet_q[i], i == octet_q.size() - 1);
    end
    octet_q.delete();
    buffers_sent++;
  endtask

  // Append one character, mostly well formed, sometimes noise or broken
  task automatic add_char();
    int unsigned kind;
    int unsigned len;
    int unsigned keep;
    int unsigned i;
    logic [7:0]  lead;
    kind = $urandom_range(0, 99);
    if (kind < 2) begin
      octet_q.push_back(NulByte);
    end else if (kind < 8) begin
      octet_q.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 12) begin
      octet_q.push_back(ContTag | 8'($urandom_range(0, 63)));
    end else begin
      len = $urandom_range(1, 6);
      case (len)
        1:       lead = 8'($urandom_range(1, 127));
        2:       lead = Lead2Tag | 8'($urandom_range(0, 31));
        3:       lead = Lead3Tag | 8'($urandom_range(0, 15));
        4:       lead = Lead4Tag | 8'($urandom_range(0, 7));
        5:       lead = Lead5Tag | 8'($urandom_range(0, 3));
        default: lead = Lead6Tag | 8'($urandom_range(0, 3));
      endcase
      octet_q.push_back(lead);
      // cut a sequence short now and then
      keep = len - 1;
      if (len > 1 && $urandom_range(0, 9) == 0) keep = $urandom_range(0, len - 2);
      for (i = 0; i < keep; i++) begin
        if ($urandom_range(0, 29) == 0) octet_q.push_back(NulByte);
        else octet_q.push_back(ContTag | 8'($urandom_range(0, 63)));
      end
    end
  endtask

  // Lead classes two to four, stray and zero continuations, overlong zero
  task automatic test_short_sequences();
    octet_q = '{8'h01, 8'hBF, 8'hC0, 8'h80, 8'hEF, 8'h00, 8'hBF,
                8'hF7, 8'hBF, 8'hBF, 8'hBF};
    flush_buffer();
  endtask

  // Five- and six-byte leads, full 31-bit value completed on the last byte
  task automatic test_long_sequences();
    octet_q = '{8'hFB, 8'h80, 8'h80, 8'h80, 8'h81,
                8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF};
    flush_buffer();
  endtask

  // Zero lead byte ending the string, and a six-byte lead cut off by the end
  task automatic test_nul_and_cutoff();
    octet_q = '{8'h7F, 8'h00, 8'hFF};
    flush_buffer();
    octet_q = '{8'hFF, 8'hBF};
    flush_buffer();
  endtask

  // Random buffers until enough bytes were sent
  task automatic test_random_buffers(input int unsigned target);
    int unsigned start;
    int unsigned chars;
    int unsigned i;
    start = bytes_sent;
    while (bytes_sent - start < target) begin
      chars = $urandom_range(1, 10);
      for (i = 0; i < chars; i++) add_char();
      flush_buffer();
    end
  endtask

  // Back-to-back buffers with no idling on either side
  task automatic test_steady_stream(input int unsigned target);
    gaps_on = 1'b0;
    test_random_buffers(target);
  endtask

  // Drive the result side ready with random stall bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else if (gaps_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(1, 6);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin : check_results
    u8dec_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected result: code_point 0x%08h is_terminator %0b",
               out_data.code_point, out_data.is_terminator);
        err_cnt++;
      end else begin
        want = decoded_q.pop_front();
        if (out_data.code_point !== want.code_point) begin
          $error("code_point mismatch: expected 0x%08h, got 0x%08h",
                 want.code_point, out_data.code_point);
          err_cnt++;
        end
        if (out_data.is_terminator !== want.is_terminator) begin
          $error("is_terminator mismatch: expected %0b, got %0b",
                 want.is_terminator, out_data.is_terminator);
          err_cnt++;
        end
        if (want.is_terminator) terms_checked++;
        else cps_checked++;
      end
    end
  end

  // End the run when no beat moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("timeout: no beat moved for %0d cycles", IdleLimit);
      $display("utf8_to_utf32_stream_decoder verification failed");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_short_sequences();
    test_long_sequences();
    test_nul_and_cutoff();
    test_random_buffers(750);
    test_steady_stream(170);

    // drain the outstanding results
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("sent %0d bytes (%0d decoded) in %0d buffers", bytes_sent, live_bytes,
             buffers_sent);
    $display("checked %0d code points and %0d terminators, %0d mismatches",
             cps_checked, terms_checked, err_cnt);
    if (err_cnt == 0) begin
      $display("utf8_to_utf32_stream_decoder verification clean");
    end else begin
      $display("utf8_to_utf32_stream_decoder verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/u8dec_pkg.sv
hdl/u8dec_in_reg.sv
hdl/u8dec_core.sv
hdl/u8dec_fifo.sv
hdl/utf8_to_utf32_stream_decoder.sv
tb/tb.sv
